@@ design/rc5pwd_pkg.sv @@
`default_nettype none
package rc5pwd_pkg;

  localparam int ShiftBits  = 32;
  localparam int WidthBits  = 14;
  localparam int TickBits   = 4;
  localparam int KeyBits    = 6;
  localparam int QueueDepth = 4;
  localparam int QPtrBits   = $clog2(QueueDepth);

  localparam logic [WidthBits-1:0] ShortMinReset = WidthBits'(600);
  localparam logic [WidthBits-1:0] ShortMaxReset = WidthBits'(1200);
  localparam logic [WidthBits-1:0] LongMinReset  = WidthBits'(1500);
  localparam logic [WidthBits-1:0] LongMaxReset  = WidthBits'(2000);
  localparam logic [TickBits-1:0]  IdleLimReset  = TickBits'(15);

  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_FALL = 2'd1,
    OP_RISE = 2'd2,
    OP_READ = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    CFG_SHORT_MIN = 3'd0,
    CFG_SHORT_MAX = 3'd1,
    CFG_LONG_MIN  = 3'd2,
    CFG_LONG_MAX  = 3'd3,
    CFG_IDLE_LIM  = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [1:0]           operation;
    logic [WidthBits-1:0] pulse_width;
  } in_item_t;

  typedef struct packed {
    logic [KeyBits-1:0] key_code;
    logic               key_valid;
    logic               frame_active;
    logic               frame_ready;
  } out_item_t;

  // classified item, ready for the back end
  typedef struct packed {
    op_t  op;
    logic short_hit;
    logic long_hit;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_xfer_t;

endpackage
`default_nettype wire

@@ design/rc5pwd_front.sv @@
`default_nettype none
module rc5pwd_front (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire rc5pwd_pkg::in_item_t           in_data,
  input  wire logic                           cfg_write,
  input  wire logic [2:0]                     cfg_index,
  input  wire logic [rc5pwd_pkg::WidthBits-1:0] cfg_data,
  input  wire logic                           q_full,
  output rc5pwd_pkg::q_xfer_t                 push,
  output logic [rc5pwd_pkg::TickBits-1:0]     idle_tick_limit
);

  logic [rc5pwd_pkg::WidthBits-1:0] short_min;
  logic [rc5pwd_pkg::WidthBits-1:0] short_max;
  logic [rc5pwd_pkg::WidthBits-1:0] long_min;
  logic [rc5pwd_pkg::WidthBits-1:0] long_max;

  always_ff @(posedge clk) begin
    if (rst) begin
      short_min       <= rc5pwd_pkg::ShortMinReset;
      short_max       <= rc5pwd_pkg::ShortMaxReset;
      long_min        <= rc5pwd_pkg::LongMinReset;
      long_max        <= rc5pwd_pkg::LongMaxReset;
      idle_tick_limit <= rc5pwd_pkg::IdleLimReset;
    end else if (cfg_write) begin
      case (rc5pwd_pkg::cfg_idx_t'(cfg_index))
        rc5pwd_pkg::CFG_SHORT_MIN: short_min <= cfg_data;
        rc5pwd_pkg::CFG_SHORT_MAX: short_max <= cfg_data;
        rc5pwd_pkg::CFG_LONG_MIN:  long_min  <= cfg_data;
        rc5pwd_pkg::CFG_LONG_MAX:  long_max  <= cfg_data;
        rc5pwd_pkg::CFG_IDLE_LIM:  idle_tick_limit <= cfg_data[rc5pwd_pkg::TickBits-1:0];
        default: ;
      endcase
    end
  end

  // strict windows; an empty or inverted window never hits
  always_comb begin
    push.valid         = in_valid && !q_full;
    push.cmd.op        = rc5pwd_pkg::op_t'(in_data.operation);
    push.cmd.short_hit = (in_data.pulse_width > short_min) && (in_data.pulse_width < short_max);
    push.cmd.long_hit  = (in_data.pulse_width > long_min) && (in_data.pulse_width < long_max);
  end

  assign in_stall = q_full;

endmodule
`default_nettype wire

@@ design/rc5pwd_queue.sv @@
`default_nettype none
module rc5pwd_queue (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire rc5pwd_pkg::q_xfer_t push,
  output logic                     full,
  output rc5pwd_pkg::q_xfer_t      head,
  input  wire logic                pop
);

  rc5pwd_pkg::cmd_t mem [rc5pwd_pkg::QueueDepth];

  logic [rc5pwd_pkg::QPtrBits-1:0] wr_ptr;
  logic [rc5pwd_pkg::QPtrBits-1:0] rd_ptr;
  logic [rc5pwd_pkg::QPtrBits:0]   count;
  logic                            do_pop;

  assign do_pop = pop && (count != '0);

  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem[wr_ptr] <= push.cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push.valid, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  assign full       = (count == (rc5pwd_pkg::QPtrBits+1)'(rc5pwd_pkg::QueueDepth));
  assign head.valid = (count != '0);
  assign head.cmd   = mem[rd_ptr];

endmodule
`default_nettype wire

@@ design/rc5pwd_back.sv @@
`default_nettype none
module rc5pwd_back (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire rc5pwd_pkg::q_xfer_t            head,
  output logic                                pop,
  input  wire logic [rc5pwd_pkg::TickBits-1:0] idle_tick_limit,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output rc5pwd_pkg::out_item_t               out_data
);

  logic                               active_flag;
  logic                               ready_flag;
  logic                               fall_seen_flag;
  logic [rc5pwd_pkg::TickBits-1:0]    idle_ticks;
  logic                               pair_flag;
  logic [rc5pwd_pkg::ShiftBits-1:0]   bit_shift;

  logic                               active_flag_next;
  logic                               ready_flag_next;
  logic                               fall_seen_flag_next;
  logic [rc5pwd_pkg::TickBits-1:0]    idle_ticks_next;
  logic                               pair_flag_next;
  logic [rc5pwd_pkg::ShiftBits-1:0]   bit_shift_next;
  logic [rc5pwd_pkg::KeyBits-1:0]     key_next;
  logic                               key_valid_next;

  assign pop = head.valid && (!out_valid || !out_stall);

  always_comb begin
    active_flag_next    = active_flag;
    ready_flag_next     = ready_flag;
    fall_seen_flag_next = fall_seen_flag;
    idle_ticks_next     = idle_ticks;
    pair_flag_next      = pair_flag;
    bit_shift_next      = bit_shift;
    key_next            = '0;
    key_valid_next      = 1'b0;
    case (head.cmd.op)
      rc5pwd_pkg::OP_TICK: begin
        if (active_flag) begin
          fall_seen_flag_next = 1'b0;
          if (idle_ticks == '0) begin
            ready_flag_next = 1'b1;
          end
          if (idle_ticks < idle_tick_limit) begin
            idle_ticks_next = idle_ticks + 1'b1;
          end else begin
            active_flag_next = 1'b0;
            idle_ticks_next  = '0;
          end
        end
      end
      rc5pwd_pkg::OP_FALL: begin
        if (active_flag && head.cmd.long_hit) begin
          pair_flag_next = 1'b0;
        end
        fall_seen_flag_next = 1'b1;
      end
      rc5pwd_pkg::OP_RISE: begin
        if (fall_seen_flag) begin
          if (active_flag) begin
            if (head.cmd.short_hit) begin
              bit_shift_next = {bit_shift[rc5pwd_pkg::ShiftBits-2:0], !pair_flag};
            end else if (head.cmd.long_hit) begin
              pair_flag_next = 1'b1;
              bit_shift_next = {bit_shift[rc5pwd_pkg::ShiftBits-3:0], 2'b10};
            end
          end else if (head.cmd.short_hit) begin
            // frame start
            active_flag_next = 1'b1;
            bit_shift_next   = rc5pwd_pkg::ShiftBits'(1);
          end
        end
        fall_seen_flag_next = 1'b0;
      end
      rc5pwd_pkg::OP_READ: begin
        if (ready_flag) begin
          bit_shift_next  = {{(rc5pwd_pkg::ShiftBits-rc5pwd_pkg::KeyBits){1'b0}},
                             bit_shift[rc5pwd_pkg::KeyBits-1:0]};
          key_next        = bit_shift[rc5pwd_pkg::KeyBits-1:0];
          key_valid_next  = 1'b1;
          ready_flag_next = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_flag    <= 1'b0;
      ready_flag     <= 1'b0;
      fall_seen_flag <= 1'b0;
      idle_ticks     <= '0;
      pair_flag      <= 1'b0;
      bit_shift      <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (pop) begin
        active_flag    <= active_flag_next;
        ready_flag     <= ready_flag_next;
        fall_seen_flag <= fall_seen_flag_next;
        idle_ticks     <= idle_ticks_next;
        pair_flag      <= pair_flag_next;
        bit_shift      <= bit_shift_next;
        out_valid      <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data.key_code     <= key_next;
      out_data.key_valid    <= key_valid_next;
      out_data.frame_active <= active_flag_next;
      out_data.frame_ready  <= ready_flag_next;
    end
  end

endmodule
`default_nettype wire

@@ design/rc5_pulse_width_decoder.sv @@
// channel   dir  handshake              payload
// in        in   in_valid / in_stall    in_data  (operation, pulse_width)
// out       out  out_valid / out_stall  out_data (key_code, key_valid, frame_active, frame_ready)
// cfg       in   cfg_write              cfg_index, cfg_data
//
// one item per cycle sustained while out_stall is low; an input transfer is written into the queue,
// then popped into the output register; front end classifies the pulse width against the windows,
// a four-entry queue holds classified items, back end updates the frame state and loads the output register
// rst is synchronous; it restores the register defaults and clears all frame state
// in_stall rises only when the queue is full; out_stall holds the output register
`default_nettype none
module rc5_pulse_width_decoder (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire rc5pwd_pkg::in_item_t             in_data,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output rc5pwd_pkg::out_item_t                 out_data,
  input  wire logic                             cfg_write,
  input  wire logic [2:0]                       cfg_index,
  input  wire logic [rc5pwd_pkg::WidthBits-1:0] cfg_data
);

  rc5pwd_pkg::q_xfer_t             push;
  rc5pwd_pkg::q_xfer_t             head;
  logic                            q_full;
  logic                            pop;
  logic [rc5pwd_pkg::TickBits-1:0] idle_tick_limit;

  rc5pwd_front u_front (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data         (in_data),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .q_full          (q_full),
    .push            (push),
    .idle_tick_limit (idle_tick_limit)
  );

  rc5pwd_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .full (q_full),
    .head (head),
    .pop  (pop)
  );

  rc5pwd_back u_back (
    .clk             (clk),
    .rst             (rst),
    .head            (head),
    .pop             (pop),
    .idle_tick_limit (idle_tick_limit),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_data        (out_data)
  );

  // a read that returns a key always clears the ready mark
  a_key_clears_ready: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.key_valid |-> !out_data.frame_ready)
    else $error("key returned while frame still marked ready");

  // a nonzero key only comes with a valid read
  a_key_needs_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.key_code != '0) |-> out_data.key_valid)
    else $error("nonzero key without key_valid");

  // the queue never takes a transfer while full
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    !(push.valid && q_full))
    else $error("push into full queue");

  // a popped item always lands in the output register
  a_pop_loads_out: assert property (@(posedge clk) disable iff (rst)
    pop |=> out_valid)
    else $error("popped item lost");

endmodule
`default_nettype wire
